>>> design/erpc_pkg.sv
// Shared types, constants and hash helper for the evidence record checker.
package erpc_pkg;

  localparam int unsigned LEN_W = 21;

  localparam logic [63:0]      FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0]      FNV_PRIME       = 64'h0000_0100_0000_01B3;
  localparam logic [LEN_W-1:0] MAX_LEN_DEFAULT = 21'h10_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_HASH      = 2'd0;
  localparam logic [1:0] REG_EXPECTED_TID  = 2'd1;
  localparam logic [1:0] REG_MAX_FIELD_LEN = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_MALFORMED  = 2'd1,
    ST_TRANSCRIPT = 2'd2,
    ST_SIGNATURE  = 2'd3
  } status_e;

  // What the back end does with one byte
  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_FOLD       = 2'd1,
    OP_TRANSCRIPT = 2'd2,
    OP_SIGNATURE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0] data;
    op_e        op;
    logic [2:0] lane;
    logic       last;
    logic       malformed;
    logic       tid_valid;
    logic       sig_valid;
  } entry_t;

  // One FNV-1a step; the prime is 2^40 + 0x1B3, so the product is shifts and adds
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

>>> design/evidence_record_parse_check.sv
// Top level of the evidence record parser and signature checker.
//
// Takes an evidence payload one byte per request (push/full) and gives one
// result per payload (empty/pop) when the byte flagged last_byte_i arrives.
// A payload holds three length-prefixed fields (32-bit little-endian length
// and that many bytes), a 64-bit little-endian transcript id, one more
// length-prefixed field and a 64-bit little-endian signature. All bytes
// before the signature are folded into a 64-bit FNV-1a hash seeded with the
// key_hash register. The status reports malformed (length over
// max_field_length, early end, or bytes after the signature), then a
// transcript mismatch against expected_transcript, then a signature
// mismatch, else acceptance; bytes after an error are dropped until the last
// byte. The block sustains one byte per clock while the queue has room: the
// parser classifies a byte in the cycle it is taken, and the hash engine
// folds one byte per clock with a shift-and-add constant multiply, which is
// the loop that sets the rate. The queue of QueueDepth entries between them
// lets the parser keep taking bytes while a finished result waits to be
// popped; a result goes through the queue and the result register to the
// ports. Write configuration only while no payload result is outstanding;
// a key_hash write takes effect from the next payload.
module evidence_record_parse_check import erpc_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status_o,
  output logic [63:0]      transcript_out_o,
  output logic [63:0]      signature_seen_o,
  output logic [63:0]      signature_computed_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [63:0]      cfg_wdata_i
);

  logic [63:0]      key_hash_q;
  logic [63:0]      expected_tid_q;
  logic [LEN_W-1:0] max_len_q;

  entry_t  front_ent, queue_ent;
  logic    front_push, queue_full, queue_empty, back_pop;
  status_e status;

  // Hold configuration; an index past the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hash_q     <= FNV_BASIS;
      expected_tid_q <= '0;
      max_len_q      <= MAX_LEN_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_HASH:      key_hash_q     <= cfg_wdata_i;
        REG_EXPECTED_TID:  expected_tid_q <= cfg_wdata_i;
        REG_MAX_FIELD_LEN: max_len_q      <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Parse and tag each byte as it is taken.
  erpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .max_len_i   (max_len_q),
    .ent_full_i  (queue_full),
    .ent_push_o  (front_push),
    .ent_o       (front_ent),
    .full_o      (full)
  );

  // Decouple the parser from the hash engine.
  erpc_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_ent),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .data_o  (queue_ent),
    .empty_o (queue_empty)
  );

  // Fold bytes and register the result until it is popped.
  erpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ent_i          (queue_ent),
    .ent_valid_i    (!queue_empty),
    .ent_pop_o      (back_pop),
    .key_hash_i     (key_hash_q),
    .expected_tid_i (expected_tid_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status),
    .transcript_o   (transcript_out_o),
    .sig_seen_o     (signature_seen_o),
    .sig_comp_o     (signature_computed_o)
  );

  assign status_o = status;

endmodule

>>> design/erpc_fifo.sv
// Short queue of classified bytes between the parser and the hash engine.
module erpc_fifo import erpc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

>>> design/erpc_front.sv
// Record parser: tracks field layout and tags each byte for the hash engine.
module erpc_front import erpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [LEN_W-1:0] max_len_i,
  input  logic             ent_full_i,
  output logic             ent_push_o,
  output entry_t           ent_o,
  output logic             full_o
);

  typedef enum logic [2:0] {
    FLD_STR0       = 3'd0,
    FLD_STR1       = 3'd1,
    FLD_STR2       = 3'd2,
    FLD_TRANSCRIPT = 3'd3,
    FLD_NONCE      = 3'd4,
    FLD_SIGNATURE  = 3'd5,
    FLD_DONE       = 3'd6
  } field_e;

  field_e           field_q, field_d;
  logic             hdr_q, hdr_d;
  logic [LEN_W-1:0] pos_q, pos_d, pos_inc;
  logic [31:0]      len_q, len_d, len_new;
  logic             err_q, err_d;
  logic             next_field;
  logic             accept;
  op_e              op;
  logic [2:0]       lane;

  assign accept     = push_i && !ent_full_i;
  assign full_o     = ent_full_i;
  assign ent_push_o = accept;
  assign pos_inc    = pos_q + LEN_W'(1);

  always_comb begin
    len_new = len_q;
    len_new[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
  end

  always_comb begin
    field_d    = field_q;
    hdr_d      = hdr_q;
    pos_d      = pos_q;
    len_d      = len_q;
    err_d      = err_q;
    next_field = 1'b0;
    op         = OP_NONE;
    lane       = pos_q[2:0];
    if (!err_q) begin
      case (field_q)
        FLD_STR0, FLD_STR1, FLD_STR2, FLD_NONCE: begin
          op = OP_FOLD;
          if (hdr_q) begin
            len_d = len_new;
            pos_d = pos_inc;
            if (pos_q[1:0] == 2'd3) begin
              if (len_new > {{(32 - LEN_W){1'b0}}, max_len_i}) begin
                err_d = 1'b1;
              end else if (len_new == '0) begin
                next_field = 1'b1;
              end else begin
                hdr_d = 1'b0;
                pos_d = '0;
              end
            end
          end else begin
            pos_d = pos_inc;
            if ({{(32 - LEN_W){1'b0}}, pos_inc} >= len_q) next_field = 1'b1;
          end
        end
        FLD_TRANSCRIPT: begin
          op    = OP_TRANSCRIPT;
          pos_d = pos_inc;
          if (pos_q[2:0] == 3'd7) next_field = 1'b1;
        end
        FLD_SIGNATURE: begin
          op    = OP_SIGNATURE;
          pos_d = pos_inc;
          if (pos_q[2:0] == 3'd7) next_field = 1'b1;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
    if (next_field) begin
      field_d = field_e'(field_q + 3'd1);
      hdr_d   = 1'b1;
      pos_d   = '0;
    end
  end

  always_comb begin
    ent_o.data      = data_byte_i;
    ent_o.op        = op;
    ent_o.lane      = lane;
    ent_o.last      = last_byte_i;
    ent_o.malformed = err_d || (field_d != FLD_DONE);
    ent_o.tid_valid = (field_d >= FLD_NONCE);
    ent_o.sig_valid = (field_d == FLD_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= FLD_STR0;
      hdr_q   <= 1'b1;
      pos_q   <= '0;
      len_q   <= '0;
      err_q   <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        field_q <= FLD_STR0;
        hdr_q   <= 1'b1;
        pos_q   <= '0;
        len_q   <= '0;
        err_q   <= 1'b0;
      end else begin
        field_q <= field_d;
        hdr_q   <= hdr_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        err_q   <= err_d;
      end
    end
  end

  // Length headers only; the fixed-size words count past four with hdr_q set
  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q && !err_q && (field_q != FLD_TRANSCRIPT) && (field_q != FLD_SIGNATURE))
      |-> (pos_q < LEN_W'(4)))
    else $error("header position past length word");

endmodule

>>> design/erpc_back.sv
// Hash engine: folds bytes, collects transcript and signature, forms the result.
module erpc_back import erpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      ent_i,
  input  logic        ent_valid_i,
  output logic        ent_pop_o,
  input  logic [63:0] key_hash_i,
  input  logic [63:0] expected_tid_i,
  input  logic        pop_i,
  output logic        empty_o,
  output status_e     status_o,
  output logic [63:0] transcript_o,
  output logic [63:0] sig_seen_o,
  output logic [63:0] sig_comp_o
);

  logic [63:0] hash_q, hash_n, base;
  logic [63:0] tid_q, tid_n;
  logic [63:0] sig_q, sig_n;
  logic        fresh_q;
  logic        consume;
  logic        res_valid_q;
  status_e     res_status_q, status_n;
  logic [63:0] res_tid_q, res_sig_q, res_comp_q;

  assign consume   = ent_valid_i && (!ent_i.last || !res_valid_q || pop_i);
  assign ent_pop_o = consume;

  // The first byte of a payload starts from the key, so a key write between
  // payloads takes effect without touching the running hash.
  assign base = fresh_q ? key_hash_i : hash_q;

  always_comb begin
    hash_n = base;
    if (ent_i.op == OP_FOLD || ent_i.op == OP_TRANSCRIPT) begin
      hash_n = fnv_fold(base, ent_i.data);
    end
    tid_n = tid_q;
    if (ent_i.op == OP_TRANSCRIPT) tid_n[{ent_i.lane, 3'b000} +: 8] = ent_i.data;
    sig_n = sig_q;
    if (ent_i.op == OP_SIGNATURE) sig_n[{ent_i.lane, 3'b000} +: 8] = ent_i.data;
  end

  // A well formed record ends on a signature byte, which does not fold, so
  // the signature compares against the hash before this byte.
  always_comb begin
    if (ent_i.malformed) begin
      status_n = ST_MALFORMED;
    end else if (tid_n != expected_tid_i) begin
      status_n = ST_TRANSCRIPT;
    end else if (sig_n != base) begin
      status_n = ST_SIGNATURE;
    end else begin
      status_n = ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      hash_q <= hash_n;
      tid_q  <= tid_n;
      sig_q  <= sig_n;
    end
    if (consume && ent_i.last) begin
      res_status_q <= status_n;
      res_tid_q    <= ent_i.tid_valid ? tid_n : '0;
      res_sig_q    <= ent_i.sig_valid ? sig_n : '0;
      res_comp_q   <= hash_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (consume) fresh_q <= ent_i.last;
      if (consume && ent_i.last) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o      = !res_valid_q;
  assign status_o     = res_status_q;
  assign transcript_o = res_tid_q;
  assign sig_seen_o   = res_sig_q;
  assign sig_comp_o   = res_comp_q;

  a_fresh_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && ent_i.last) |=> fresh_q)
    else $error("hash not restarted after payload end");

  a_malformed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && ent_i.last && ent_i.malformed) |=> (res_status_q == ST_MALFORMED))
    else $error("malformed record not reported");

endmodule
